// File: hw/rtl/qpd_pkg.sv
// shared types, constants and sine table builder for the quadratic phase dechirp block
package qpd_pkg;

	// data path widths
	localparam int SAMPLE_BITS     = 16;
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int CFG_BITS        = 32;

	// derived sizes
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int TAB_N       = 1 << TABLE_ADDR_BITS;
	localparam int PHASE_SHIFT = PHASE_BITS - 2 - TABLE_ADDR_BITS;
	localparam int K_SHL       = (PHASE_BITS >= CFG_BITS) ? PHASE_BITS - CFG_BITS : 0;
	localparam int K_SHR       = (PHASE_BITS < CFG_BITS) ? CFG_BITS - PHASE_BITS : 0;

	// phase state memory
	localparam int STATE_DEPTH = 1;
	localparam int STATE_AW    = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

	// quarter cycle in radians, Q30
	localparam logic [63:0] QUARTER_PI2_Q30 = 64'd1686629713;

	// unity magnitude of the table
	localparam logic signed [SAMPLE_BITS:0] ONE = (SAMPLE_BITS + 1)'(1 << FRAC_BITS);

	typedef logic [SAMPLE_BITS-1:0] sin_tab_t [TAB_N+1];

	// phase recurrence state: k*n*n and k*(2n+1)
	typedef struct packed {
		logic [PHASE_BITS-1:0] acc;
		logic [PHASE_BITS-1:0] incr;
	} qpd_state_t;

	// table lookup stage payload
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          bypass;
		logic [1:0]                    quad;
		logic [TABLE_ADDR_BITS-1:0]    addr;
	} qpd_s1_t;

	// mixer stage payload
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          bypass;
		logic signed [SAMPLE_BITS:0]   cos_val;
		logic signed [SAMPLE_BITS:0]   sin_val;
	} qpd_s2_t;

	// quarter-wave sine magnitudes, taylor series in Q30, evaluated at elaboration
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t           tab;
		logic [63:0]        x;
		logic [63:0]        t;
		logic [63:0]        v;
		logic [63:0]        one;
		logic signed [63:0] sum;
		int                 i;
		int                 k;
		one = 64'd1 << FRAC_BITS;
		for (i = 0; i <= TAB_N; i++) begin
			x   = (QUARTER_PI2_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
			t   = x;
			sum = signed'(x);
			for (k = 1; k <= 7; k++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / 64'((2 * k) * (2 * k + 1));
				if (k[0])
					sum = sum - signed'(t);
				else
					sum = sum + signed'(t);
			end
			if (sum < 0)
				sum = 64'sd0;
			v = ((64'(sum) << FRAC_BITS) + (64'd1 << 29)) >> 30;
			if (v > one)
				v = one;
			tab[i] = v[SAMPLE_BITS-1:0];
		end
		return tab;
	endfunction

endpackage

// File: hw/rtl/qpd_ram.sv
// generic single-write, single-read ram with registered read data
module qpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [1 << AW];

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/qpd_phase.sv
// input stage: phase recurrence held in the state ram, table address generation
module qpd_phase import qpd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          first,
	input  logic [PHASE_BITS-1:0]         step,
	input  logic                          bypass,
	output logic                          s1_valid,
	input  logic                          s1_ready,
	output qpd_s1_t                       s1
);

	localparam logic [PHASE_BITS-1:0] RND = PHASE_BITS'((PHASE_SHIFT > 0) ?
		(64'd1 << ((PHASE_SHIFT > 0) ? PHASE_SHIFT - 1 : 0)) : 64'd0);
	localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

	qpd_state_t                   rd_data;
	qpd_state_t                   cur;
	qpd_state_t                   nxt;
	qpd_state_t                   last_q;
	logic                         wrote_q;
	logic                         init_q;
	logic                         fire;
	logic [PHASE_BITS-1:0]        acc0;
	logic [PHASE_BITS-1:0]        incr0;
	logic [PHASE_BITS-1:0]        rnd_phase;
	logic [TABLE_ADDR_BITS+1:0]   idx;
	logic                         valid_s1;
	qpd_s1_t                      pipe_s1;

	assign in_ready = !valid_s1 || s1_ready;
	assign fire     = in_valid && in_ready;

	// state memory, one entry, rewritten on every accepted beat
	qpd_ram #(
		.WIDTH(2 * PHASE_BITS),
		.DEPTH(STATE_DEPTH)
	) u_state (
		.clk   (clk),
		.we    (fire),
		.waddr (STATE_ADDR),
		.wdata (nxt),
		.raddr (STATE_ADDR),
		.rdata (rd_data)
	);

	// forward the last write, zero state until the first write
	always_comb begin
		if (wrote_q)
			cur = last_q;
		else if (init_q)
			cur = rd_data;
		else
			cur = '0;
	end

	// recurrence update and rounded table index
	always_comb begin
		acc0      = first ? '0 : cur.acc;
		incr0     = first ? step : cur.incr;
		nxt.acc   = acc0 + incr0;
		nxt.incr  = incr0 + {step[PHASE_BITS-2:0], 1'b0};
		rnd_phase = acc0 + RND;
		idx       = rnd_phase[PHASE_BITS-1:PHASE_SHIFT];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrote_q  <= 1'b0;
			init_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			wrote_q <= fire;
			if (fire)
				init_q <= 1'b1;
			if (in_ready)
				valid_s1 <= in_valid;
		end
	end

	// forwarding copy and stage payload
	always_ff @(posedge clk) begin
		if (fire) begin
			last_q         <= nxt;
			pipe_s1.re     <= sample_re;
			pipe_s1.im     <= sample_im;
			pipe_s1.bypass <= bypass;
			pipe_s1.quad   <= idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
			pipe_s1.addr   <= idx[TABLE_ADDR_BITS-1:0];
		end
	end

	assign s1_valid = valid_s1;
	assign s1       = pipe_s1;

endmodule

// File: hw/rtl/qpd_sincos.sv
// quarter-wave table lookup with quadrant folding, registered read
module qpd_sincos import qpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s1_valid,
	output logic    s1_ready,
	input  qpd_s1_t s1,
	output logic    s2_valid,
	input  logic    s2_ready,
	output qpd_s2_t s2
);

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	logic [TABLE_ADDR_BITS:0]      mirror;
	logic signed [SAMPLE_BITS-1:0] re_s2;
	logic signed [SAMPLE_BITS-1:0] im_s2;
	logic                          bypass_s2;
	logic [1:0]                    quad_s2;
	logic [SAMPLE_BITS-1:0]        mag_a_s2;
	logic [SAMPLE_BITS-1:0]        mag_b_s2;
	logic signed [SAMPLE_BITS:0]   sa;
	logic signed [SAMPLE_BITS:0]   sb;
	logic signed [SAMPLE_BITS:0]   cos_v;
	logic signed [SAMPLE_BITS:0]   sin_v;
	logic                          load;
	logic                          valid_s2;

	assign s1_ready = !valid_s2 || s2_ready;
	assign load     = s1_valid && s1_ready;

	// mirrored table address
	assign mirror = (TABLE_ADDR_BITS + 1)'(TAB_N) - {1'b0, s1.addr};

	// direct and mirrored table reads into the stage registers
	always_ff @(posedge clk) begin
		if (load) begin
			re_s2     <= s1.re;
			im_s2     <= s1.im;
			bypass_s2 <= s1.bypass;
			quad_s2   <= s1.quad;
			mag_a_s2  <= SIN_TAB[{1'b0, s1.addr}];
			mag_b_s2  <= SIN_TAB[mirror];
		end
	end

	// quadrant folding on the registered magnitudes
	always_comb begin
		sa = signed'({1'b0, mag_a_s2});
		sb = signed'({1'b0, mag_b_s2});
		case (quad_s2)
			QUAD_I: begin
				cos_v = sb;
				sin_v = sa;
			end
			QUAD_II: begin
				cos_v = -sa;
				sin_v = sb;
			end
			QUAD_III: begin
				cos_v = -sb;
				sin_v = -sa;
			end
			QUAD_IV: begin
				cos_v = sa;
				sin_v = -sb;
			end
			default: begin
				cos_v = sb;
				sin_v = sa;
			end
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= s1_valid;
		end
	end

	// stage payload
	always_comb begin
		s2.re      = re_s2;
		s2.im      = im_s2;
		s2.bypass  = bypass_s2;
		s2.cos_val = cos_v;
		s2.sin_val = sin_v;
	end

	assign s2_valid = valid_s2;

endmodule

// File: hw/rtl/qpd_mix.sv
// complex multiply, rounding, saturation and output register
module qpd_mix import qpd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s2_valid,
	output logic                        s2_ready,
	input  qpd_s2_t                     s2,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [SAMPLE_BITS:0] out_re,
	output logic signed [SAMPLE_BITS:0] out_im
);

	localparam int PW = 2 * SAMPLE_BITS + 1;
	localparam int SW = PW + 1;
	localparam int RW = SW - FRAC_BITS;
	localparam logic signed [SW-1:0] RND  = SW'(64'sd1 << (FRAC_BITS - 1));
	localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 << SAMPLE_BITS) - 64'sd1);
	localparam logic signed [RW-1:0] MINV = RW'(-(64'sd1 << SAMPLE_BITS));

	logic signed [PW-1:0]          p_rc_s3;
	logic signed [PW-1:0]          p_is_s3;
	logic signed [PW-1:0]          p_rs_s3;
	logic signed [PW-1:0]          p_ic_s3;
	logic signed [SAMPLE_BITS-1:0] re_s3;
	logic signed [SAMPLE_BITS-1:0] im_s3;
	logic                          bypass_s3;
	logic                          valid_s3;
	logic                          out_free;
	logic signed [SW-1:0]          sum_re;
	logic signed [SW-1:0]          sum_im;
	logic signed [SAMPLE_BITS:0]   res_re;
	logic signed [SAMPLE_BITS:0]   res_im;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS:0]   out_re_q;
	logic signed [SAMPLE_BITS:0]   out_im_q;

	// round half up to the sample fraction and clamp to the output range
	function automatic logic signed [SAMPLE_BITS:0] round_sat(input logic signed [SW-1:0] acc);
		logic signed [SW-1:0] r;
		logic signed [RW-1:0] q;
		r = acc + RND;
		q = r[SW-1:FRAC_BITS];
		if (q > MAXV)
			q = MAXV;
		else if (q < MINV)
			q = MINV;
		return (SAMPLE_BITS + 1)'(q);
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign s2_ready = !valid_s3 || out_free;

	// stage and output valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready)
				valid_s3 <= s2_valid;
			if (out_free)
				out_valid_q <= valid_s3;
		end
	end

	// four partial products
	always_ff @(posedge clk) begin
		if (s2_valid && s2_ready) begin
			p_rc_s3   <= s2.re * s2.cos_val;
			p_is_s3   <= s2.im * s2.sin_val;
			p_rs_s3   <= s2.re * s2.sin_val;
			p_ic_s3   <= s2.im * s2.cos_val;
			re_s3     <= s2.re;
			im_s3     <= s2.im;
			bypass_s3 <= s2.bypass;
		end
	end

	// sums and result selection
	always_comb begin
		sum_re = {p_rc_s3[PW-1], p_rc_s3} - {p_is_s3[PW-1], p_is_s3};
		sum_im = {p_rs_s3[PW-1], p_rs_s3} + {p_ic_s3[PW-1], p_ic_s3};
		if (bypass_s3) begin
			res_re = {re_s3[SAMPLE_BITS-1], re_s3};
			res_im = {im_s3[SAMPLE_BITS-1], im_s3};
		end else begin
			res_re = round_sat(sum_re);
			res_im = round_sat(sum_im);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (valid_s3 && out_free) begin
			out_re_q <= res_re;
			out_im_q <= res_im;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;

endmodule

// File: hw/rtl/quadratic_phase_dechirp.sv
// top level of the quadratic phase dechirp mixer
// Multiplies each complex Q1.15 sample by exp(+i*2*pi*k*n*n), n counting from the last
// beat flagged first, k set by the chirp step register (zero passes samples through).
// Takes one sample per clock cycle when the output side does not stall, and returns
// results in input order; throughput is set by the phase state, a one-entry ram
// that is read and rewritten every accepted beat with the last write forwarded, so
// back-to-back beats see the fresh phase. Stages: phase update, quarter-wave table
// lookup (two reads), four 16x17 multiplies, round/saturate into the output register.
// No clearing pass after reset; the state reads as zero until the first accepted beat.
// Write the chirp step only while the block is idle.
module quadratic_phase_dechirp import qpd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          first,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS:0]   out_re,
	output logic signed [SAMPLE_BITS:0]   out_im
);

	logic signed [CFG_BITS-1:0] chirp_step_q;
	logic [63:0]                k_wide;
	logic [PHASE_BITS-1:0]      step;
	logic                       bypass;
	logic                       s1_valid;
	logic                       s1_ready;
	qpd_s1_t                    s1;
	logic                       s2_valid;
	logic                       s2_ready;
	qpd_s2_t                    s2;

	// chirp step register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chirp_step_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			chirp_step_q <= cfg_data;
		end
	end

	// step scaled to the phase width
	always_comb begin
		k_wide = (64'(chirp_step_q) << K_SHL) >> K_SHR;
		step   = k_wide[PHASE_BITS-1:0];
		bypass = (chirp_step_q == '0);
	end

	qpd_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.first     (first),
		.step      (step),
		.bypass    (bypass),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1        (s1)
	);

	qpd_sincos u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1       (s1),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2       (s2)
	);

	qpd_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid),
		.s2_ready  (s2_ready),
		.s2        (s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_re    (out_re),
		.out_im    (out_im)
	);

`ifndef SYNTHESIS
	// a block start always looks up zero phase
	a_first_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && first) |=> (s1.quad == 2'd0 && s1.addr == '0))
		else $error("first beat did not map to zero phase");

	// with the output register empty the pipeline must take input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// folded table values stay within unit magnitude
	a_unit_magnitude: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid |-> (s2.cos_val <= ONE && s2.cos_val >= -ONE &&
			s2.sin_val <= ONE && s2.sin_val >= -ONE))
		else $error("table output exceeds unit magnitude");
`endif

endmodule

// File: verif/qpd_checker.sv
// checker for the dechirp mixer: tracks chirp phase, predicts each output beat and compares
module qpd_checker import qpd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          first,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [SAMPLE_BITS:0]   out_re,
	input  logic signed [SAMPLE_BITS:0]   out_im,
	output int                            mismatch_count,
	output int                            mix_pending,
	output int                            mix_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// phase word and lookup geometry of this build
	localparam int PH_BITS   = 32;
	localparam int LUT_BITS  = 10;
	localparam int LUT_LEN   = 1 << LUT_BITS;
	localparam int RND_POS   = PH_BITS - 2 - LUT_BITS;
	localparam int Q_FRAC    = SAMPLE_BITS - 1;
	localparam longint OUT_MAX = (longint'(1) << SAMPLE_BITS) - 1;
	localparam longint OUT_MIN = -(longint'(1) << SAMPLE_BITS);
	// a quarter turn in radians, Q30
	localparam longint unsigned QTR_TURN_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [SAMPLE_BITS:0] re;
		logic signed [SAMPLE_BITS:0] im;
	} mix_t;

	int          sine_mag [LUT_LEN+1];
	logic [31:0] step_k;
	logic [31:0] chirp_acc;
	logic [31:0] chirp_incr;
	mix_t        expected_mix [$];

	initial begin
		mismatch_count = 0;
		mix_pending    = 0;
		mix_checked    = 0;
	end

	// sin(pi/2 * idx / LUT_LEN) by odd-power series in Q30, rounded to Q_FRAC bits
	function automatic int quarter_sine(int unsigned idx);
		longint unsigned ang;
		longint unsigned term;
		longint unsigned mag;
		longint          acc;
		ang  = (QTR_TURN_Q30 * idx) >> LUT_BITS;
		term = ang;
		acc  = longint'(ang);
		for (int j = 1; j <= 7; j++) begin
			term = (term * ang) >> 30;
			term = (term * ang) >> 30;
			term = term / longint'((2 * j) * (2 * j + 1));
			acc  = (j % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		mag = ((longint'(acc) << Q_FRAC) + (64'd1 << 29)) >> 30;
		if (mag > (64'd1 << Q_FRAC))
			mag = 64'd1 << Q_FRAC;
		return int'(mag);
	endfunction

	initial begin
		for (int i = 0; i <= LUT_LEN; i++)
			sine_mag[i] = quarter_sine(i);
	end

	// drop the extra fraction bits, round half up, clamp to the output range
	function automatic logic signed [SAMPLE_BITS:0] round_to_out(longint v);
		longint r;
		r = (v + (longint'(1) << (Q_FRAC - 1))) >>> Q_FRAC;
		if (r > OUT_MAX)
			r = OUT_MAX;
		if (r < OUT_MIN)
			r = OUT_MIN;
		return r[SAMPLE_BITS:0];
	endfunction

	// rotate one sample by the current chirp phase, then advance the phase recurrence
	function automatic mix_t rotate_sample(logic signed [SAMPLE_BITS-1:0] re,
			logic signed [SAMPLE_BITS-1:0] im, logic fst);
		mix_t                 res;
		logic [PH_BITS-1:0]   rounded;
		logic [LUT_BITS+1:0]  idx;
		logic [1:0]           quad;
		logic [LUT_BITS-1:0]  addr;
		longint               cv;
		longint               sv;
		longint               mag_a;
		longint               mag_m;
		if (fst) begin
			chirp_acc  = '0;
			chirp_incr = step_k;
		end
		rounded = chirp_acc + (PH_BITS'(1) << (RND_POS - 1));
		idx     = rounded[PH_BITS-1 -: LUT_BITS+2];
		quad    = idx[LUT_BITS+1:LUT_BITS];
		addr    = idx[LUT_BITS-1:0];
		mag_a   = sine_mag[addr];
		mag_m   = sine_mag[LUT_LEN - int'(addr)];
		case (quad)
			2'd0: begin cv =  mag_m; sv =  mag_a; end
			2'd1: begin cv = -mag_a; sv =  mag_m; end
			2'd2: begin cv = -mag_m; sv = -mag_a; end
			default: begin cv = mag_a; sv = -mag_m; end
		endcase
		// zero step passes the sample through, sign extended
		if (step_k == '0) begin
			res.re = re;
			res.im = im;
		end else begin
			res.re = round_to_out(longint'(re) * cv - longint'(im) * sv);
			res.im = round_to_out(longint'(re) * sv + longint'(im) * cv);
		end
		chirp_acc  = chirp_acc + chirp_incr;
		chirp_incr = chirp_incr + (step_k << 1);
		return res;
	endfunction

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		mix_t got;
		mix_t want;
		if (!arst_n) begin
			step_k     = '0;
			chirp_acc  = '0;
			chirp_incr = '0;
			expected_mix.delete();
			mix_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				step_k = cfg_data;
			if (in_valid && in_ready)
				expected_mix.push_back(rotate_sample(sample_re, sample_im, first));
			// output beat against the oldest prediction
			if (out_valid && out_ready) begin
				got.re = out_re;
				got.im = out_im;
				if (expected_mix.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected output beat re=%0d im=%0d at %0t",
							got.re, got.im, $time);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_mix.pop_front();
					if (got != want) begin
						if (mismatch_count < 10)
							$display("mismatch at %0t: expected re=%0d im=%0d, got re=%0d im=%0d",
								$time, want.re, want.im, got.re, got.im);
						mismatch_count <= mismatch_count + 1;
					end
				end
				mix_checked <= mix_checked + 1;
			end
			mix_pending <= expected_mix.size();
		end
	end

endmodule

// File: verif/tb_top.sv
// testbench top for the dechirp mixer: clock, reset, stimulus, stalls and verdict
module tb_top;
	import qpd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_BITS-1:0]           cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_re = '0;
	logic signed [SAMPLE_BITS-1:0] sample_im = '0;
	logic                          first     = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS:0]   out_re;
	logic signed [SAMPLE_BITS:0]   out_im;

	int mismatch_count;
	int mix_pending;
	int mix_checked;

	// idle percentages per phase and the long output hold
	int send_idle     = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int beats_sent    = 0;
	int steps_written = 0;

	quadratic_phase_dechirp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_re    (out_re),
		.out_im    (out_im)
	);

	qpd_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_re      (sample_re),
		.sample_im      (sample_im),
		.first          (first),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_re         (out_re),
		.out_im         (out_im),
		.mismatch_count (mismatch_count),
		.mix_pending    (mix_pending),
		.mix_checked    (mix_checked)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// output side: random stalls, or a counted hold when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// one chirp step write beat
	task automatic write_step(input logic [CFG_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		steps_written++;
	endtask

	// one sample beat, then a random gap with valid low
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] re,
			input logic [SAMPLE_BITS-1:0] im, input logic fst);
		in_valid  <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		first     <= fst;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	// stop sending, wait until every predicted beat has come out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (mix_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// sample values with extra weight on the extremes
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// chirp step for each random phase, extremes among them
	function automatic logic [CFG_BITS-1:0] step_for(int ph);
		case (ph)
			0: return 32'hFFFF_FFFF;
			2: return 32'h0000_0000;
			4: return 32'h8000_0000;
			5: return $urandom_range(1, 4096);
			6: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stim
		int          sent;
		int          len;
		bit          opens;
		bit          mid_done;
		logic        fst;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// bypass after reset, samples before any block start
		push_sample(16'h7FFF, 16'h7FFF, 1'b0);
		push_sample(16'h8000, 16'h8000, 1'b0);
		push_sample(16'h8000, 16'h7FFF, 1'b0);
		push_sample(16'h0000, 16'h0000, 1'b1);
		push_sample(16'hFFFF, 16'h0001, 1'b0);

		// 3/16 turn step walks through several quadrants
		drain();
		write_step(32'h3000_0000);
		push_sample(16'h8000, 16'h8000, 1'b1);
		push_sample(16'h7FFF, 16'h8000, 1'b0);
		push_sample(16'h8000, 16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 16'h7FFF, 1'b0);
		push_sample(16'h4000, 16'hC000, 1'b0);
		push_sample(16'h0000, 16'h8000, 1'b0);

		// step changed inside a block, most negative step
		drain();
		write_step(32'h8000_0000);
		push_sample(16'h7FFF, 16'h0000, 1'b0);
		push_sample(16'h0000, 16'h7FFF, 1'b0);
		push_sample(16'h8000, 16'h8000, 1'b0);

		// most positive step, then the smallest
		drain();
		write_step(32'h7FFF_FFFF);
		push_sample(16'h7FFF, 16'h8000, 1'b1);
		push_sample(16'h8000, 16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 16'h7FFF, 1'b0);
		push_sample(16'h8000, 16'h8000, 1'b0);
		drain();
		write_step(32'h0000_0001);
		push_sample(16'h7FFF, 16'h7FFF, 1'b1);
		push_sample(16'h8000, 16'h0001, 1'b0);
		push_sample(16'h5A5A, 16'hA5A5, 1'b0);

		// random blocks, a new step and an idle mix for each phase
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_step(step_for(ph));
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 82; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 82; end
				default: begin send_idle = 33; stall_pct = 33; end
			endcase
			sent     = 0;
			mid_done = 1'b0;
			while (sent < 80) begin
				len   = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
				opens = ($urandom_range(9) != 0);
				for (int j = 0; j < len && sent < 80; j++) begin
					// halfway: long output hold, full pause, or a step change mid-block
					if (!mid_done && sent >= 40) begin
						mid_done = 1'b1;
						case (ph % 3)
							0: if (hold_left == 0) hold_left <= 200;
							1: drain();
							default: begin
								in_valid <= 1'b0;
								drain();
								write_step($urandom);
							end
						endcase
					end
					fst = (j == 0) ? opens : ($urandom_range(49) == 0);
					push_sample(pick_sample(), pick_sample(), fst);
					sent++;
				end
			end
			in_valid <= 1'b0;
		end

		in_valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d samples, %0d step writes, %0d output beats checked",
			beats_sent, steps_written, mix_checked);
		$display("bypass, extreme steps, mid-block step changes, long output hold, idle mixes");
		if (mismatch_count == 0 && mix_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/qpd_pkg.sv
hw/rtl/qpd_ram.sv
hw/rtl/qpd_phase.sv
hw/rtl/qpd_sincos.sv
hw/rtl/qpd_mix.sv
hw/rtl/quadratic_phase_dechirp.sv
verif/qpd_checker.sv
verif/tb_top.sv
